@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define MH_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition must never be true out of reset.
`define MH_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

@@ design/mhash_pkg.sv @@
// ----------------------------------------------------------------------------
// mhash_pkg
// Types and constants shared by the MurmurHash2 controller and datapath.
// ----------------------------------------------------------------------------
package mhash_pkg;

	localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
	localparam int          MIX_SHIFT   = 24;
	localparam int          FIN_SHIFT_A = 13;
	localparam int          FIN_SHIFT_B = 15;
	localparam logic [31:0] SEED_RESET  = 32'd97;

	localparam logic [1:0]  REG_HASH_SEED = 2'd0;

	typedef enum logic [2:0] {
		OP_K1,
		OP_K2,
		OP_H,
		OP_T,
		OP_F
	} op_t;

	typedef struct packed {
		logic load;
		logic mul;
		op_t  op;
	} cmd_t;

	function automatic logic [31:0] tail_mask(input logic [1:0] cnt);
		logic [31:0] m;
		unique case (cnt)
			2'd1:    m = 32'h0000_00ff;
			2'd2:    m = 32'h0000_ffff;
			2'd3:    m = 32'h00ff_ffff;
			default: m = 32'h0000_0000;
		endcase
		return m;
	endfunction

endpackage

@@ design/mhash_ctrl.sv @@
// ----------------------------------------------------------------------------
// mhash_ctrl
// Sequencer for the hash: accepts a request and steps the shared multiplier.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mhash_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [2:0]          byte_count,
	input  logic                last_word,
	input  logic                out_busy,
	output mhash_pkg::cmd_t     cmd
);
	import mhash_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_K1,
		ST_K2,
		ST_H,
		ST_T,
		ST_FIN
	} state_t;

	state_t state_q;
	logic   last_q;
	logic   accept;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			last_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						last_q <= last_word;
						priority if (byte_count[2])
							state_q <= ST_K1;
						else if (byte_count != 3'd0)
							state_q <= ST_T;
						else if (last_word)
							state_q <= ST_FIN;
						else
							state_q <= ST_IDLE;
					end
				end
				ST_K1: state_q <= ST_K2;
				ST_K2: state_q <= ST_H;
				ST_H:  state_q <= last_q ? ST_FIN : ST_IDLE;
				ST_T:  state_q <= last_q ? ST_FIN : ST_IDLE;
				ST_FIN: begin
					if (!out_busy)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd.load = accept;
		cmd.mul  = 1'b0;
		cmd.op   = OP_K1;
		unique case (state_q)
			ST_K1:  begin cmd.mul = 1'b1; cmd.op = OP_K1; end
			ST_K2:  begin cmd.mul = 1'b1; cmd.op = OP_K2; end
			ST_H:   begin cmd.mul = 1'b1; cmd.op = OP_H;  end
			ST_T:   begin cmd.mul = 1'b1; cmd.op = OP_T;  end
			ST_FIN: begin cmd.mul = !out_busy; cmd.op = OP_F; end
			default: cmd.mul = 1'b0;
		endcase
	end

	`MH_ASSERT(a_full_word_mixes, (accept && byte_count[2]) |=> (state_q == ST_K1), "full word did not start k mixing")
	`MH_ASSERT(a_empty_mid_word, (accept && byte_count == 3'd0 && !last_word) |=> (state_q == ST_IDLE), "empty word left controller busy")

endmodule

@@ design/mhash_dp.sv @@
// ----------------------------------------------------------------------------
// mhash_dp
// Datapath: word and accumulator registers, one shared multiplier by m,
// and the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mhash_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  mhash_pkg::cmd_t     cmd,
	input  logic [31:0]         hash_seed,
	input  logic [31:0]         data_word,
	input  logic [2:0]          byte_count,
	input  logic                first_word,
	input  logic [30:0]         key_length,
	output logic                out_busy,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [31:0]         hash_value
);
	import mhash_pkg::*;

	logic [31:0] word_q;
	logic [1:0]  cnt_q;
	logic [31:0] h_q;
	logic [31:0] k_q;
	logic [31:0] hash_q;
	logic        out_valid_q;
	logic [31:0] mul_a;
	logic [31:0] prod;

	always_comb begin
		unique case (cmd.op)
			OP_K1:   mul_a = word_q;
			OP_K2:   mul_a = k_q;
			OP_H:    mul_a = h_q;
			OP_T:    mul_a = h_q ^ (word_q & tail_mask(cnt_q));
			OP_F:    mul_a = h_q ^ (h_q >> FIN_SHIFT_A);
			default: mul_a = word_q;
		endcase
	end

	assign prod = mul_a * MIX_MUL;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q <= '0;
		end else if (cmd.load) begin
			if (first_word)
				h_q <= hash_seed ^ {1'b0, key_length};
		end else if (cmd.mul && cmd.op == OP_H) begin
			h_q <= prod ^ k_q;
		end else if (cmd.mul && cmd.op == OP_T) begin
			h_q <= prod;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			word_q <= data_word;
			cnt_q  <= byte_count[1:0];
		end
		if (cmd.mul && cmd.op == OP_K1)
			k_q <= prod ^ (prod >> MIX_SHIFT);
		else if (cmd.mul && cmd.op == OP_K2)
			k_q <= prod;
		if (cmd.mul && cmd.op == OP_F)
			hash_q <= prod ^ (prod >> FIN_SHIFT_B);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.mul && cmd.op == OP_F)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	assign out_busy   = out_valid_q && out_stall;
	assign out_valid  = out_valid_q;
	assign hash_value = hash_q;

	`MH_NEVER(a_no_overwrite, cmd.mul && cmd.op == OP_F && out_valid_q && out_stall, "result overwritten while stalled")
	`MH_ASSERT(a_acc_keeps, (cmd.load && !first_word) |=> $stable(h_q), "continuing word disturbed accumulator")

endmodule

@@ design/murmur2_hash_32.sv @@
// ----------------------------------------------------------------------------
// murmur2_hash_32
// MurmurHash2 (32-bit) of a key streamed as little-endian words.
// A request is taken only while idle (in_stall is low). It then uses 3 steps
// of the shared multiplier for a full word, 1 for a partial word, none for an
// empty one, plus 1 finishing step on the last word (held while the result
// stalls). Result is valid in the cycle after the finishing step. Reset clears
// the accumulator and sets hash_seed to 97.
// ----------------------------------------------------------------------------
module murmur2_hash_32 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] data_word,
	input  logic [2:0]  byte_count,
	input  logic        first_word,
	input  logic        last_word,
	input  logic [30:0] key_length,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] hash_value
);
	import mhash_pkg::*;

	logic [31:0] seed_q;
	logic        out_busy;
	cmd_t        cmd;

	assign pready = 1'b1;
	assign prdata = (paddr == REG_HASH_SEED) ? seed_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			seed_q <= SEED_RESET;
		else if (psel && penable && pwrite)
			seed_q <= pwdata;
	end

	mhash_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.byte_count (byte_count),
		.last_word  (last_word),
		.out_busy   (out_busy),
		.cmd        (cmd)
	);

	mhash_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.hash_seed  (seed_q),
		.data_word  (data_word),
		.byte_count (byte_count),
		.first_word (first_word),
		.key_length (key_length),
		.out_busy   (out_busy),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.hash_value (hash_value)
	);

endmodule
